// ===== rtl/fnms_pkg.sv =====
// Shared types, constants and helpers for the fuzzy name match scorer.
package fnms_pkg;

	// Default sizing handed to the top level
	localparam int QueryMaxDefault   = 16;
	localparam int NameMaxLenDefault = 511;

	// Query register layout: two 64-bit words, eight bytes each
	localparam int QuerySlots = 16;
	localparam int CountW     = 5;
	localparam int BonusW     = 8;
	localparam int ScoreW     = 17;
	localparam int IndexW     = 20;
	localparam int CfgIndexW  = 2;

	// Score constants
	localparam logic [8:0] ScoreExact    = 9'd300;
	localparam logic [8:0] ScoreInitials = 9'd200;
	localparam logic [8:0] ScoreFuzzy    = 9'd100;
	localparam logic [BonusW-1:0] AdjStep = 8'd10;

	// Word separators
	localparam logic [7:0] SepSpace = 8'h20;
	localparam logic [7:0] SepDash  = 8'h2d;
	localparam logic [7:0] SepUnder = 8'h5f;

	// Configuration register indexes
	localparam logic [CfgIndexW-1:0] RegQueryLow  = 2'd0;
	localparam logic [CfgIndexW-1:0] RegQueryHigh = 2'd1;
	localparam logic [CfgIndexW-1:0] RegQueryLen  = 2'd2;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_EXACT    = 2'd1,
		KIND_INITIALS = 2'd2,
		KIND_FUZZY    = 2'd3
	} match_kind_t;

	typedef struct packed {
		logic [7:0]  name_char;
		logic        last_char;
		logic [15:0] freq_bonus;
	} char_item_t;

	typedef struct packed {
		logic [ScoreW-1:0] match_score;
		logic [1:0]        match_kind;
		logic [IndexW-1:0] name_index;
	} score_item_t;

	// Per-cycle control shared by every cell of the chain
	typedef struct packed {
		logic take;
		logic clear;
	} cell_ctrl_t;

	// Fold ASCII upper case to lower case
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic upper;
		upper = (c >= 8'h41) && (c <= 8'h5a);
		return upper ? (c + 8'd32) : c;
	endfunction

endpackage

// ===== rtl/fnms_cell.sv =====
// One cell of the substring chain: tracks a partial query match ending here.
module fnms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fnms_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          name_char,
	input  logic [7:0]          query_char,
	input  logic                left_match,
	output logic                match,
	output logic                hit
);
	import fnms_pkg::*;

	logic match_q;

	// Extend the neighbour's prefix match by the current character
	assign hit   = left_match && (name_char == query_char);
	assign match = match_q;

	// Hold the prefix flag, clear it at the end of each name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.clear) begin
			match_q <= 1'b0;
		end else if (ctrl.take) begin
			match_q <= hit;
		end
	end

endmodule

// ===== rtl/fuzzy_name_match_scorer.sv =====
// Latency: the score register loads at the edge that takes a name's last character.
// Throughput: one name character per cycle; the chain of QUERY_MAX cells and the
// initials and subsequence counters all update in the cycle a character is taken.
// A full score register whose transfer is stalled holds off the next character.
// Reset clears the query to zero with length one, all per-name state and the name count.
module fuzzy_name_match_scorer #(
	parameter int QUERY_MAX    = fnms_pkg::QueryMaxDefault,
	parameter int NAME_MAX_LEN = fnms_pkg::NameMaxLenDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             char_valid,
	output logic                             char_stall,
	input  fnms_pkg::char_item_t             char_data,
	output logic                             score_valid,
	input  logic                             score_stall,
	output fnms_pkg::score_item_t            score_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fnms_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [63:0]                      cfg_data
);
	import fnms_pkg::*;

	localparam int PosW = $clog2(NAME_MAX_LEN + 1);

	// Configuration registers
	logic [63:0]       query_low_q;
	logic [63:0]       query_high_q;
	logic [CountW-1:0] query_len_q;

	// Per-name state
	logic [PosW-1:0]   char_pos_q;
	logic              exact_found_q;
	logic [CountW-1:0] initials_q;
	logic              after_sep_q;
	logic [CountW-1:0] fuzzy_q;
	logic              prev_match_q;
	logic [BonusW-1:0] adj_bonus_q;
	logic [IndexW-1:0] names_seen_q;

	// Output register
	logic              score_valid_q;
	score_item_t       score_data_q;

	logic              accept;
	logic              take;
	logic [7:0]        c;
	logic [CountW-1:0] eff_len;
	logic [7:0]        query_fold [QuerySlots];
	cell_ctrl_t        ctrl;
	logic [QUERY_MAX-1:0] cell_match;
	logic [QUERY_MAX-1:0] cell_hit;
	logic              exact_hit;

	logic              exact_nxt;
	logic [CountW-1:0] initials_nxt;
	logic              after_sep_nxt;
	logic [CountW-1:0] fuzzy_nxt;
	logic              prev_match_nxt;
	logic [BonusW-1:0] adj_bonus_nxt;
	logic              is_sep;
	logic [7:0]        init_q_char;
	logic [7:0]        fuzzy_q_char;

	logic [8:0]        base_score;
	logic [1:0]        kind;
	logic [ScoreW-1:0] final_score;

	// Handshakes
	assign cfg_ready  = 1'b1;
	assign char_stall = score_valid_q && score_stall;
	assign accept     = char_valid && !char_stall;
	assign take       = accept && (char_pos_q < PosW'(NAME_MAX_LEN));
	assign c          = fold(char_data.name_char);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_low_q  <= '0;
			query_high_q <= '0;
			query_len_q  <= CountW'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegQueryLow:  query_low_q  <= cfg_data;
				RegQueryHigh: query_high_q <= cfg_data;
				RegQueryLen:  query_len_q  <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the query length into one to QUERY_MAX
	always_comb begin
		if (query_len_q == '0) begin
			eff_len = CountW'(1);
		end else if (query_len_q > CountW'(QUERY_MAX)) begin
			eff_len = CountW'(QUERY_MAX);
		end else begin
			eff_len = query_len_q;
		end
	end

	// Fold query bytes
	always_comb begin
		for (int i = 0; i < QuerySlots / 2; i++) begin
			query_fold[i]                  = fold(query_low_q[8*i +: 8]);
			query_fold[i + QuerySlots / 2] = fold(query_high_q[8*i +: 8]);
		end
	end

	assign ctrl.take  = take;
	assign ctrl.clear = accept && char_data.last_char;

	// Substring chain: cell k flags a match of query bytes 0..k ending at this character
	for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
		logic left;
		if (k == 0) begin : g_head
			assign left = 1'b1;
		end else begin : g_link
			assign left = cell_match[k-1];
		end
		fnms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.name_char  (c),
			.query_char (query_fold[k]),
			.left_match (left),
			.match      (cell_match[k]),
			.hit        (cell_hit[k])
		);
	end

	// Pick the cell at the query's last position
	always_comb begin
		exact_hit = 1'b0;
		for (int k = 0; k < QUERY_MAX; k++) begin
			if (eff_len == CountW'(k + 1)) begin
				exact_hit = cell_hit[k];
			end
		end
	end

	assign exact_nxt    = exact_found_q || (take && exact_hit);
	assign is_sep       = (c == SepSpace) || (c == SepDash) || (c == SepUnder);
	assign init_q_char  = query_fold[initials_q[3:0]];
	assign fuzzy_q_char = query_fold[fuzzy_q[3:0]];

	// Advance the word-initials matcher
	always_comb begin
		initials_nxt  = initials_q;
		after_sep_nxt = after_sep_q;
		if (take && (initials_q < eff_len)) begin
			if (is_sep) begin
				after_sep_nxt = 1'b1;
			end else if (after_sep_q) begin
				if (c == init_q_char) begin
					initials_nxt = initials_q + CountW'(1);
				end
				after_sep_nxt = 1'b0;
			end
		end
	end

	// Advance the subsequence matcher and its adjacency bonus
	always_comb begin
		fuzzy_nxt      = fuzzy_q;
		prev_match_nxt = prev_match_q;
		adj_bonus_nxt  = adj_bonus_q;
		if (take && (fuzzy_q < eff_len)) begin
			if (c == fuzzy_q_char) begin
				if (prev_match_q) begin
					adj_bonus_nxt = adj_bonus_q + AdjStep;
				end
				fuzzy_nxt      = fuzzy_q + CountW'(1);
				prev_match_nxt = 1'b1;
			end else begin
				prev_match_nxt = 1'b0;
			end
		end
	end

	// Rank the matchers and add the bonus to a nonzero score
	always_comb begin
		if (exact_nxt) begin
			base_score = ScoreExact;
			kind       = KIND_EXACT;
		end else if (initials_nxt >= eff_len) begin
			base_score = ScoreInitials;
			kind       = KIND_INITIALS;
		end else if (fuzzy_nxt >= eff_len) begin
			base_score = ScoreFuzzy + 9'(adj_bonus_nxt);
			kind       = KIND_FUZZY;
		end else begin
			base_score = '0;
			kind       = KIND_NONE;
		end
		if (kind == KIND_NONE) begin
			final_score = '0;
		end else begin
			final_score = ScoreW'(base_score) + ScoreW'(char_data.freq_bonus);
		end
	end

	// Update per-name state, clear it after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos_q    <= '0;
			exact_found_q <= 1'b0;
			initials_q    <= '0;
			after_sep_q   <= 1'b1;
			fuzzy_q       <= '0;
			prev_match_q  <= 1'b1;
			adj_bonus_q   <= '0;
			names_seen_q  <= '0;
		end else if (accept) begin
			if (char_data.last_char) begin
				char_pos_q    <= '0;
				exact_found_q <= 1'b0;
				initials_q    <= '0;
				after_sep_q   <= 1'b1;
				fuzzy_q       <= '0;
				prev_match_q  <= 1'b1;
				adj_bonus_q   <= '0;
				names_seen_q  <= names_seen_q + IndexW'(1);
			end else begin
				if (take) begin
					char_pos_q <= char_pos_q + PosW'(1);
				end
				exact_found_q <= exact_nxt;
				initials_q    <= initials_nxt;
				after_sep_q   <= after_sep_nxt;
				fuzzy_q       <= fuzzy_nxt;
				prev_match_q  <= prev_match_nxt;
				adj_bonus_q   <= adj_bonus_nxt;
			end
		end
	end

	// Load the score register on a name's last character, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_valid_q <= 1'b0;
		end else if (accept && char_data.last_char) begin
			score_valid_q <= 1'b1;
		end else if (!score_stall) begin
			score_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && char_data.last_char) begin
			score_data_q.match_score <= final_score;
			score_data_q.match_kind  <= kind;
			score_data_q.name_index  <= names_seen_q;
		end
	end

	assign score_valid = score_valid_q;
	assign score_data  = score_data_q;

endmodule

// ===== test/score_checker.sv =====
// Checker for the fuzzy name match scorer: predicts each name's score and compares results.
`timescale 1ns / 1ps

module score_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           char_valid,
	input  logic                           char_stall,
	input  fnms_pkg::char_item_t           char_data,
	input  logic                           score_valid,
	input  logic                           score_stall,
	input  fnms_pkg::score_item_t          score_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fnms_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	output int                             fail_count,
	output int                             pending_count
);
	import fnms_pkg::*;

	localparam int NameLimit = NameMaxLenDefault;
	localparam int HistDepth = QuerySlots - 1;
	localparam int ShowLimit = 10;

	// Query registers as the block should hold them
	logic [63:0] query_lo;
	logic [63:0] query_hi;
	logic [4:0]  query_len_reg;

	// Per-name matcher state
	logic [7:0]        history [HistDepth];
	logic [9:0]        name_pos;
	logic              substr_hit;
	logic [4:0]        initials_cnt;
	logic              word_start;
	logic [4:0]        subseq_cnt;
	logic              last_hit;
	logic [7:0]        adj_bonus;
	logic [IndexW-1:0] names_done;

	score_item_t expected_scores [$];
	int          shown;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return c | 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] query_at(input int i);
		logic [127:0] whole;
		whole = {query_hi, query_lo};
		return to_lower(whole[8*i +: 8]);
	endfunction

	function automatic void clear_name();
		int k;
		for (k = 0; k < HistDepth; k++) history[k] = 8'h00;
		name_pos     = '0;
		substr_hit   = 1'b0;
		initials_cnt = '0;
		word_start   = 1'b1;
		subseq_cnt   = '0;
		last_hit     = 1'b1;
		adj_bonus    = '0;
	endfunction

	// Track every transfer; results are checked before the character of the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		int            n;
		int            k;
		logic          hit;
		logic [7:0]    c;
		logic [ScoreW-1:0] score;
		match_kind_t   kind;
		score_item_t   want;
		logic          bad;

		if (!arst_n) begin
			query_lo      = '0;
			query_hi      = '0;
			query_len_reg = 5'd1;
			names_done    = '0;
			clear_name();
			expected_scores.delete();
			fail_count    = 0;
			pending_count = 0;
			shown         = 0;
		end else begin
			// compare a result transfer with the oldest expected score
			if (score_valid && !score_stall) begin
				if (expected_scores.size() == 0) begin
					fail_count++;
					if (shown < ShowLimit) begin
						shown++;
						$display("%0t: unexpected score %0d kind %0d index %0d", $realtime,
							score_data.match_score, score_data.match_kind,
							score_data.name_index);
					end
				end else begin
					want = expected_scores.pop_front();
					bad  = (score_data.match_score !== want.match_score) ||
						(score_data.match_kind !== want.match_kind) ||
						(score_data.name_index !== want.name_index);
					if (bad) begin
						fail_count++;
						if (shown < ShowLimit) begin
							shown++;
							$display("%0t: name %0d expected score %0d kind %0d index %0d, got %0d %0d %0d",
								$realtime, want.name_index, want.match_score,
								want.match_kind, want.name_index, score_data.match_score,
								score_data.match_kind, score_data.name_index);
						end
					end
				end
			end

			// advance the matchers on a character transfer
			if (char_valid && !char_stall) begin
				n = int'(query_len_reg);
				if (n < 1) n = 1;
				if (n > QuerySlots) n = QuerySlots;
				c = to_lower(char_data.name_char);

				if (int'(name_pos) < NameLimit) begin
					// contiguous substring ending at this character
					if (!substr_hit && int'(name_pos) + 1 >= n) begin
						hit = (query_at(n - 1) == c);
						for (k = 1; k < n; k++)
							if (query_at(n - 1 - k) != history[k - 1]) hit = 1'b0;
						if (hit) substr_hit = 1'b1;
					end
					for (k = HistDepth - 1; k > 0; k--) history[k] = history[k - 1];
					history[0] = c;

					// word initials
					if (int'(initials_cnt) < n) begin
						if (c == SepSpace || c == SepDash || c == SepUnder) begin
							word_start = 1'b1;
						end else if (word_start) begin
							if (c == query_at(int'(initials_cnt))) initials_cnt++;
							word_start = 1'b0;
						end
					end

					// in-order subsequence with adjacency bonus
					if (int'(subseq_cnt) < n) begin
						if (c == query_at(int'(subseq_cnt))) begin
							if (last_hit) adj_bonus = adj_bonus + AdjStep;
							subseq_cnt++;
							last_hit = 1'b1;
						end else begin
							last_hit = 1'b0;
						end
					end
					name_pos++;
				end

				if (char_data.last_char) begin
					kind  = KIND_NONE;
					score = '0;
					if (substr_hit) begin
						kind  = KIND_EXACT;
						score = ScoreExact;
					end else if (int'(initials_cnt) >= n) begin
						kind  = KIND_INITIALS;
						score = ScoreInitials;
					end else if (int'(subseq_cnt) >= n) begin
						kind  = KIND_FUZZY;
						score = ScoreFuzzy;
						score = score + adj_bonus;
					end
					if (kind != KIND_NONE) score = score + char_data.freq_bonus;
					want.match_score = score;
					want.match_kind  = kind;
					want.name_index  = names_done;
					expected_scores.push_back(want);
					names_done++;
					clear_name();
				end
			end

			// register writes take effect from the next edge
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegQueryLow:  query_lo = cfg_data;
					RegQueryHigh: query_hi = cfg_data;
					RegQueryLen:  query_len_reg = cfg_data[4:0];
					default: ;
				endcase
			end
			pending_count = expected_scores.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the fuzzy name match scorer: stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb;
	import fnms_pkg::*;

	localparam int NameLimit     = NameMaxLenDefault;
	localparam int RandomItems   = 1400;
	localparam int CycleLimit    = 400000;
	localparam int HoldOffCycles = 300;
	localparam int SettleCycles  = 4;
	localparam logic [CfgIndexW-1:0] RegSpare = 2'd3;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 char_valid  = 1'b0;
	logic                 char_stall;
	char_item_t           char_data   = '0;
	logic                 score_valid;
	logic                 score_stall = 1'b0;
	score_item_t          score_data;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index   = '0;
	logic [63:0]          cfg_data    = '0;

	int fail_count;
	int pending_count;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int cycle_count   = 0;
	int items_sent    = 0;

	logic [7:0] query_text [QuerySlots];
	int         query_used = 1;
	logic [7:0] name_buf [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fuzzy_name_match_scorer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.score_valid(score_valid),
		.score_stall(score_stall),
		.score_data (score_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	score_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_data    (char_data),
		.score_valid  (score_valid),
		.score_stall  (score_stall),
		.score_data   (score_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// Stall the score channel at random, or hold it off for a long stretch on request
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HoldOffCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			score_stall <= 1'b1;
		end else begin
			score_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one character and hold it until the transfer
	task automatic put_char(input logic [7:0] c, input logic fin, input logic [15:0] bonus);
		char_item_t item;
		item.name_char  = c;
		item.last_char  = fin;
		item.freq_bonus = bonus;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= item;
		@(posedge clk);
		while (char_stall) @(posedge clk);
	endtask

	// Drop valid and wait until every score has come back
	task automatic wait_idle();
		@(negedge clk);
		char_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(2))
			0:       return SepSpace;
			1:       return SepDash;
			default: return SepUnder;
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return 8'($urandom_range("z", "a"));
	endfunction

	function automatic logic [7:0] vary_case(input logic [7:0] c);
		if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1) == 1)
			return c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] pick_filler();
		int r;
		r = $urandom_range(99);
		if (r < 40) return pick_letter();
		if (r < 60) return pick_letter() ^ 8'h20;
		if (r < 75) return vary_case(query_text[$urandom_range(query_used - 1)]);
		if (r < 85) return pick_sep();
		return 8'($urandom_range(255));
	endfunction

	// Pick a fresh query, now and then with an out-of-range length code
	task automatic new_query();
		int          r;
		int          i;
		int          len_code;
		logic [63:0] lo;
		logic [63:0] hi;
		r = $urandom_range(99);
		if (r < 60) query_used = $urandom_range(4, 1);
		else if (r < 90) query_used = $urandom_range(15, 5);
		else query_used = QuerySlots;
		len_code = query_used;
		r = $urandom_range(99);
		if (r < 8) begin
			query_used = 1;
			len_code   = 0;
		end else if (r < 16) begin
			query_used = QuerySlots;
			len_code   = $urandom_range(31, 17);
		end
		for (i = 0; i < QuerySlots; i++) begin
			r = $urandom_range(99);
			if (i >= query_used || r >= 90) query_text[i] = 8'($urandom_range(255));
			else if (r < 70) query_text[i] = pick_letter();
			else if (r < 85) query_text[i] = pick_letter() ^ 8'h20;
			else query_text[i] = pick_sep();
		end
		for (i = 0; i < 8; i++) begin
			lo[8*i +: 8] = query_text[i];
			hi[8*i +: 8] = query_text[i + 8];
		end
		write_reg(RegQueryLow, lo);
		write_reg(RegQueryHigh, hi);
		write_reg(RegQueryLen, {32'($urandom()), 27'($urandom()), 5'(len_code)});
	endtask

	// Build a name that aims at one matcher, breaks a match, or is plain noise
	task automatic make_name();
		int r;
		int i;
		int skip;
		name_buf.delete();
		r = $urandom_range(99);
		if (r < 20) begin
			repeat ($urandom_range(3)) name_buf.push_back(pick_filler());
			for (i = 0; i < query_used; i++) name_buf.push_back(vary_case(query_text[i]));
			repeat ($urandom_range(3)) name_buf.push_back(pick_filler());
		end else if (r < 40) begin
			repeat ($urandom_range(1)) name_buf.push_back(pick_sep());
			for (i = 0; i < query_used; i++) begin
				if (i > 0) repeat ($urandom_range(2, 1)) name_buf.push_back(pick_sep());
				name_buf.push_back(vary_case(query_text[i]));
				repeat ($urandom_range(3)) name_buf.push_back(pick_letter());
			end
		end else if (r < 80) begin
			// subsequence, with one query character left out in the broken case
			skip = (r < 65) ? -1 : $urandom_range(query_used - 1);
			for (i = 0; i < query_used; i++) begin
				repeat ($urandom_range(2)) name_buf.push_back(pick_filler());
				if (i != skip) name_buf.push_back(vary_case(query_text[i]));
			end
			repeat ($urandom_range(2)) name_buf.push_back(pick_filler());
		end else begin
			repeat ($urandom_range(12, 1)) name_buf.push_back(8'($urandom_range(255)));
		end
		if (name_buf.size() == 0) name_buf.push_back(pick_filler());
	endtask

	task automatic send_name();
		int         i;
		logic [15:0] bonus;
		for (i = 0; i < name_buf.size(); i++) begin
			case ($urandom_range(7))
				0:       bonus = '0;
				1:       bonus = '1;
				default: bonus = 16'($urandom_range(65535));
			endcase
			put_char(name_buf[i], i == name_buf.size() - 1, bonus);
			if (i < NameLimit) items_sent++;
		end
	endtask

	initial begin
		int i;
		int block;
		int total;
		bit long_done;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset query is a single zero byte: a zero byte matches it
		put_char(8'h00, 1'b1, 16'hFFFF);
		wait_idle();

		// two-letter query given in upper case
		write_reg(RegQueryLow, 64'hFFFF_FFFF_FFFF_4241);
		write_reg(RegQueryHigh, '1);
		write_reg(RegQueryLen, 64'd2);
		put_char("A", 1'b0, 16'h1234);
		put_char("B", 1'b1, 16'h0000);
		put_char("a", 1'b0, 16'h0001);
		put_char("-", 1'b0, 16'h0001);
		put_char("b", 1'b1, 16'h8000);
		put_char("a", 1'b0, 16'h0000);
		put_char("x", 1'b0, 16'h0000);
		put_char("b", 1'b1, 16'h00FF);
		put_char("z", 1'b1, 16'hFFFF);

		// shorten the query halfway through a name
		put_char("a", 1'b0, 16'h0000);
		wait_idle();
		write_reg(RegQueryLen, 64'd1);
		write_reg(RegSpare, '1);
		put_char("z", 1'b1, 16'h0042);

		// full-width query with a length code past the limit
		wait_idle();
		write_reg(RegQueryLow, 64'h6867_6665_6463_6261);
		write_reg(RegQueryHigh, 64'h706F_6E6D_6C6B_6A69);
		write_reg(RegQueryLen, '1);
		for (i = 0; i < QuerySlots; i++)
			put_char(8'("a" + i) ^ ((i >= 8) ? 8'h20 : 8'h00), i == QuerySlots - 1,
				16'($urandom_range(65535)));

		// random names in blocks, a fresh query per block
		items_sent = 0;
		block      = 0;
		long_done  = 1'b0;
		while (items_sent < RandomItems) begin
			wait_idle();
			case ((items_sent * 3) / RandomItems)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			new_query();
			if (block == 1) hold_requests++;

			// one name near the length cut-off, ending in the query, so the query may fall before, across or past the cut-off
			if (!long_done && items_sent * 3 >= RandomItems) begin
				name_buf.delete();
				total = $urandom_range(NameLimit + 8, NameLimit - 2);
				while (name_buf.size() < total - query_used) name_buf.push_back(pick_letter());
				for (i = 0; i < query_used; i++) name_buf.push_back(query_text[i]);
				send_name();
				long_done = 1'b1;
			end

			repeat ($urandom_range(20, 8)) begin
				make_name();
				send_name();
			end
			block++;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
